/* sv/oriented_rect_sat_collision_macros.svh */
// assertion macros for the oriented rectangle collision block
// used by oriented_rect_sat_collision.sv, expects clk and rst_n in scope
`ifndef ORIENTED_RECT_SAT_COLLISION_MACROS_SVH
`define ORIENTED_RECT_SAT_COLLISION_MACROS_SVH
`ifndef SYNTHESIS
`define ORSAT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("orsat assertion failed");
`define ORSAT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("orsat forbidden condition");
`else
`define ORSAT_ASSERT(lbl, prop)
`define ORSAT_NEVER(lbl, expr)
`endif
`endif

/* sv/orsat_pkg.sv */
// package for the oriented rectangle collision block
// widths, sine polynomial constants and the geometry type; no dependencies
package orsat_pkg;

    localparam int CW       = 24;
    localparam int HW       = CW - 1;
    localparam int DW       = CW + 1;
    localparam int AW       = 16;
    localparam int FW       = AW - 2;
    localparam int XW       = 17;
    localparam int QW       = 16;
    localparam int MW       = 41;
    localparam int PW       = 30;
    localparam int RW       = 54;
    localparam int LW       = 57;
    localparam int OW       = LW + 1;
    localparam int NST      = 9;
    localparam int IN_W     = 224;
    localparam int OUT_W    = 64;
    localparam int QSH      = 14;
    localparam int DSH      = 28;

    localparam logic [XW-1:0] X_ONE    = 17'd65536;
    localparam logic [12:0]   SIN_C    = 13'd4640;
    localparam logic [15:0]   SIN_B    = 16'd42047;
    localparam logic [XW-1:0] SIN_A    = 17'd102944;
    localparam logic [14:0]   ONE_Q14  = 15'd16384;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [HW-1:0]        hx;
        logic [HW-1:0]        hy;
        logic [1:0]           quad;
    } rect_t;

endpackage

/* sv/oriented_rect_sat_collision.sv */
// oriented rectangle collision, separating-axis test over four axes
// depends on orsat_pkg and oriented_rect_sat_collision_macros.svh
//
// Nine-stage pipeline taking one rectangle pair per cycle unless the output
// stalls. Stages 1-4 evaluate the quarter-sine polynomial (one multiply step
// each), stage 5 forms the axis dot products, stage 6 the projected radii,
// stages 7-8 the intervals and overlaps, stage 9 picks the axis of least
// overlap and holds the result. Each stage has its own valid bit, so bubbles
// close up while the output is stalled.
`include "oriented_rect_sat_collision_macros.svh"
module oriented_rect_sat_collision
    import orsat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // a_center_x, a_center_y, a_half_x, a_half_y, a_angle,
    // b_center_x, b_center_y, b_half_x, b_half_y, b_angle, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit, normal_x, normal_y, depth, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    rect_t                in_rect [2];
    logic [AW-1:0]        in_ang  [2];
    logic [XW-1:0]        x_in    [4];

    logic [XW-1:0]        x_s1_reg [4];
    logic [XW-1:0]        x2_s1_reg [4];
    rect_t                g_s1_reg [2];
    logic [XW-1:0]        x_s2_reg [4];
    logic [XW-1:0]        x2_s2_reg [4];
    logic [15:0]          t1_s2_reg [4];
    rect_t                g_s2_reg [2];
    logic [XW-1:0]        x_s3_reg [4];
    logic [XW-1:0]        t2_s3_reg [4];
    rect_t                g_s3_reg [2];
    logic signed [QW-1:0] co_s4_reg [2];
    logic signed [QW-1:0] si_s4_reg [2];
    rect_t                g_s4_reg [2];

    logic signed [QW-1:0] co_s5_reg [2];
    logic signed [QW-1:0] si_s5_reg [2];
    rect_t                g_s5_reg [2];
    logic signed [MW-1:0] mid_s5_reg [4][2];
    logic [PW-1:0]        p1_s5_reg [4][2];
    logic [PW-1:0]        p2_s5_reg [4][2];

    logic signed [QW-1:0] co_s6_reg [2];
    logic signed [QW-1:0] si_s6_reg [2];
    logic signed [MW-1:0] mid_s6_reg [4][2];
    logic [RW-1:0]        rad_s6_reg [4][2];
    logic [3:0]           dpos_s6_reg;

    logic signed [QW-1:0] co_s7_reg [2];
    logic signed [QW-1:0] si_s7_reg [2];
    logic signed [LW-1:0] lo_s7_reg [4][2];
    logic signed [LW-1:0] hi_s7_reg [4][2];
    logic [3:0]           dpos_s7_reg;

    logic signed [QW-1:0] co_s8_reg [2];
    logic signed [QW-1:0] si_s8_reg [2];
    logic signed [OW-1:0] ov_s8_reg [4];
    logic [3:0]           sep_s8_reg;
    logic [3:0]           dpos_s8_reg;

    logic                 hit_reg;
    logic signed [QW-1:0] nx_reg;
    logic signed [QW-1:0] ny_reg;
    logic [DW-1:0]        depth_reg;

    logic signed [QW-1:0] co_next [2];
    logic signed [QW-1:0] si_next [2];
    logic signed [QW-1:0] ux5 [4];
    logic signed [QW-1:0] uy5 [4];
    logic signed [QW-1:0] ux8 [4];
    logic signed [QW-1:0] uy8 [4];
    logic                 hit_next;
    logic signed [QW-1:0] nx_next;
    logic signed [QW-1:0] ny_next;
    logic [DW-1:0]        depth_next;

    // handshake and per-stage enables
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = {6'd0, depth_reg, ny_reg, nx_reg, hit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // unpack the item
    always_comb
    begin
        in_rect[0].cx   = $signed(s_tdata[23:0]);
        in_rect[0].cy   = $signed(s_tdata[47:24]);
        in_rect[0].hx   = s_tdata[70:48];
        in_rect[0].hy   = s_tdata[93:71];
        in_ang[0]       = s_tdata[109:94];
        in_rect[1].cx   = $signed(s_tdata[133:110]);
        in_rect[1].cy   = $signed(s_tdata[157:134]);
        in_rect[1].hx   = s_tdata[180:158];
        in_rect[1].hy   = s_tdata[203:181];
        in_ang[1]       = s_tdata[219:204];
        for (int r = 0; r < 2; r++)
        begin
            in_rect[r].quad = in_ang[r][AW-1:FW];
            x_in[2*r]       = {1'b0, in_ang[r][FW-1:0], 2'b00};
            x_in[2*r+1]     = X_ONE - x_in[2*r];
        end
    end

    // sine stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                x_s1_reg[i]  <= x_in[i];
                x2_s1_reg[i] <= XW'((34'(x_in[i]) * 34'(x_in[i])) >> 16);
            end
            g_s1_reg <= in_rect;
        end
        if (en[1])
        begin
            for (int i = 0; i < 4; i++)
            begin
                x_s2_reg[i]  <= x_s1_reg[i];
                x2_s2_reg[i] <= x2_s1_reg[i];
                t1_s2_reg[i] <= SIN_B - 16'((30'(SIN_C) * 30'(x2_s1_reg[i])) >> 16);
            end
            g_s2_reg <= g_s1_reg;
        end
        if (en[2])
        begin
            for (int i = 0; i < 4; i++)
            begin
                x_s3_reg[i]  <= x_s2_reg[i];
                t2_s3_reg[i] <= SIN_A
                    - XW'((33'(t1_s2_reg[i]) * 33'(x2_s2_reg[i])) >> 16);
            end
            g_s3_reg <= g_s2_reg;
        end
        if (en[3])
        begin
            co_s4_reg <= co_next;
            si_s4_reg <= si_next;
            g_s4_reg  <= g_s3_reg;
        end
    end

    // finish sine, round and clamp, then fold quadrant
    always_comb
    begin
        logic [17:0] y;
        logic [14:0] sv [4];
        logic signed [QW-1:0] sp;
        logic signed [QW-1:0] cp;
        for (int i = 0; i < 4; i++)
        begin
            y     = 18'((34'(t2_s3_reg[i]) * 34'(x_s3_reg[i])) >> 16);
            y     = (y + 18'd2) >> 2;
            sv[i] = (y > 18'(ONE_Q14)) ? ONE_Q14 : y[14:0];
        end
        for (int r = 0; r < 2; r++)
        begin
            sp = $signed({1'b0, sv[2*r]});
            cp = $signed({1'b0, sv[2*r+1]});
            case (g_s3_reg[r].quad)
                QUAD_0:
                begin
                    si_next[r] = sp;
                    co_next[r] = cp;
                end
                QUAD_1:
                begin
                    si_next[r] = cp;
                    co_next[r] = -sp;
                end
                QUAD_2:
                begin
                    si_next[r] = -sp;
                    co_next[r] = -cp;
                end
                default:
                begin
                    si_next[r] = -cp;
                    co_next[r] = sp;
                end
            endcase
        end
    end

    // axes: each direction and its quarter turn
    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            ux5[2*r]   = co_s4_reg[r];
            uy5[2*r]   = si_s4_reg[r];
            ux5[2*r+1] = -si_s4_reg[r];
            uy5[2*r+1] = co_s4_reg[r];
            ux8[2*r]   = co_s8_reg[r];
            uy8[2*r]   = si_s8_reg[r];
            ux8[2*r+1] = -si_s8_reg[r];
            uy8[2*r+1] = co_s8_reg[r];
        end
    end

    // projection stages
    always_ff @(posedge clk)
    begin
        logic signed [32:0] pa;
        logic signed [32:0] pb;
        if (en[4])
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int r = 0; r < 2; r++)
                begin
                    mid_s5_reg[k][r] <= MW'(ux5[k] * $signed(g_s4_reg[r].cx))
                                      + MW'(uy5[k] * $signed(g_s4_reg[r].cy));
                    pa = 33'(ux5[k] * co_s4_reg[r]) + 33'(uy5[k] * si_s4_reg[r]);
                    pb = 33'(uy5[k] * co_s4_reg[r]) - 33'(ux5[k] * si_s4_reg[r]);
                    p1_s5_reg[k][r] <= (pa < 0) ? PW'(-pa) : PW'(pa);
                    p2_s5_reg[k][r] <= (pb < 0) ? PW'(-pb) : PW'(pb);
                end
            end
            co_s5_reg <= co_s4_reg;
            si_s5_reg <= si_s4_reg;
            g_s5_reg  <= g_s4_reg;
        end
        if (en[5])
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int r = 0; r < 2; r++)
                begin
                    rad_s6_reg[k][r] <= RW'(p1_s5_reg[k][r]) * RW'(g_s5_reg[r].hx)
                                      + RW'(p2_s5_reg[k][r]) * RW'(g_s5_reg[r].hy);
                end
                dpos_s6_reg[k] <= mid_s5_reg[k][1] > mid_s5_reg[k][0];
            end
            mid_s6_reg <= mid_s5_reg;
            co_s6_reg  <= co_s5_reg;
            si_s6_reg  <= si_s5_reg;
        end
        if (en[6])
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int r = 0; r < 2; r++)
                begin
                    lo_s7_reg[k][r] <= (LW'(mid_s6_reg[k][r]) <<< QSH)
                                     - $signed(LW'(rad_s6_reg[k][r]));
                    hi_s7_reg[k][r] <= (LW'(mid_s6_reg[k][r]) <<< QSH)
                                     + $signed(LW'(rad_s6_reg[k][r]));
                end
            end
            dpos_s7_reg <= dpos_s6_reg;
            co_s7_reg   <= co_s6_reg;
            si_s7_reg   <= si_s6_reg;
        end
    end

    // interval overlap per axis
    always_ff @(posedge clk)
    begin
        logic signed [LW-1:0] mn_hi;
        logic signed [LW-1:0] mx_lo;
        if (en[7])
        begin
            for (int k = 0; k < 4; k++)
            begin
                mn_hi = (hi_s7_reg[k][0] < hi_s7_reg[k][1]) ? hi_s7_reg[k][0]
                                                             : hi_s7_reg[k][1];
                mx_lo = (lo_s7_reg[k][0] > lo_s7_reg[k][1]) ? lo_s7_reg[k][0]
                                                             : lo_s7_reg[k][1];
                ov_s8_reg[k]  <= OW'(mn_hi) - OW'(mx_lo);
                sep_s8_reg[k] <= !(lo_s7_reg[k][0] <= hi_s7_reg[k][1]
                                && lo_s7_reg[k][1] <= hi_s7_reg[k][0]);
            end
            dpos_s8_reg <= dpos_s7_reg;
            co_s8_reg   <= co_s7_reg;
            si_s8_reg   <= si_s7_reg;
        end
    end

    // least overlap, earliest axis on ties
    always_comb
    begin
        logic [1:0] w01;
        logic [1:0] w23;
        logic [1:0] w;
        logic [OW-1:0] ov;
        w01 = (ov_s8_reg[1] < ov_s8_reg[0]) ? 2'd1 : 2'd0;
        w23 = (ov_s8_reg[3] < ov_s8_reg[2]) ? 2'd3 : 2'd2;
        w   = (ov_s8_reg[w23] < ov_s8_reg[w01]) ? w23 : w01;
        ov  = ov_s8_reg[w];
        hit_next = !(|sep_s8_reg);
        if (!hit_next)
        begin
            nx_next    = '0;
            ny_next    = '0;
            depth_next = '0;
        end
        else
        begin
            nx_next    = dpos_s8_reg[w] ? -ux8[w] : ux8[w];
            ny_next    = dpos_s8_reg[w] ? -uy8[w] : uy8[w];
            depth_next = (|ov[OW-1:DSH+DW]) ? {DW{1'b1}} : ov[DSH+DW-1:DSH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            hit_reg   <= hit_next;
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            depth_reg <= depth_next;
        end
    end

    `ORSAT_ASSERT(a_nohit_zero, m_tvalid && !hit_reg |-> nx_reg == 0 && ny_reg == 0 && depth_reg == 0)
    `ORSAT_ASSERT(a_accept_enters, s_tvalid && s_tready |=> v_reg[0])
    `ORSAT_NEVER(a_full_takes, (&v_reg) && !m_tready && s_tready)
    `ORSAT_ASSERT(a_unit_normal, m_tvalid && hit_reg |-> nx_reg >= -16384 && nx_reg <= 16384 && ny_reg >= -16384 && ny_reg <= 16384)

endmodule

/* bench/oriented_rect_sat_collision_checker.sv */
// result checker for the oriented rectangle collision block
// predicts the separating-axis outcome per accepted pair; depends on orsat_pkg
`timescale 1ns / 100ps
module oriented_rect_sat_collision_checker
    import orsat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        longint cx, cy, hx, hy, co, si;
    } box_t;

    logic [OUT_W-1:0] contact_q[$];

    assign pending = contact_q.size();

    function automatic longint qsine(longint x);
        longint x2, t, y, r;
        x2 = (x * x) >>> 16;
        t = (longint'(SIN_C) * x2) >>> 16;
        t = longint'(SIN_B) - t;
        t = (t * x2) >>> 16;
        t = longint'(SIN_A) - t;
        y = (t * x) >>> 16;
        r = (y + 2) >>> 2;
        return (r > 16384) ? 16384 : r;
    endfunction

    function automatic void rotation(input logic [AW-1:0] ang, output longint c,
                                     output longint s);
        longint x, sx, cx;
        x = longint'(ang[FW-1:0]) << (16 - FW);
        sx = qsine(x);
        cx = qsine(65536 - x);
        case (ang[AW-1:AW-2])
            QUAD_0: begin s = sx; c = cx; end
            QUAD_1: begin s = cx; c = -sx; end
            QUAD_2: begin s = -sx; c = -cx; end
            default: begin s = -cx; c = sx; end
        endcase
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void interval(input box_t r, input longint ux, input longint uy,
                                     output longint lo, output longint hi);
        longint mid, rad;
        mid = (ux * r.cx + uy * r.cy) * 16384;
        rad = mag(ux * r.co + uy * r.si) * r.hx + mag(uy * r.co - ux * r.si) * r.hy;
        lo = mid - rad;
        hi = mid + rad;
    endfunction

    function automatic logic [OUT_W-1:0] sat_contact(input logic [IN_W-1:0] d);
        box_t ra, rb;
        longint ax[4], ay[4];
        longint loa, hia, lob, hib, ov, best, nx, ny, dot, dep;
        logic [AW-1:0] aa, ba;
        logic sep;
        ra.cx = longint'($signed(d[23:0]));
        ra.cy = longint'($signed(d[47:24]));
        ra.hx = longint'(d[70:48]);
        ra.hy = longint'(d[93:71]);
        aa = d[109:94];
        rb.cx = longint'($signed(d[133:110]));
        rb.cy = longint'($signed(d[157:134]));
        rb.hx = longint'(d[180:158]);
        rb.hy = longint'(d[203:181]);
        ba = d[219:204];
        rotation(aa, ra.co, ra.si);
        rotation(ba, rb.co, rb.si);
        ax[0] = ra.co; ay[0] = ra.si;
        rotation(aa + AW'(1 << FW), ax[1], ay[1]);
        ax[2] = rb.co; ay[2] = rb.si;
        rotation(ba + AW'(1 << FW), ax[3], ay[3]);
        sep = 1'b0;
        best = 0; nx = 0; ny = 0;
        for (int i = 0; i < 4; i++)
        begin
            interval(ra, ax[i], ay[i], loa, hia);
            interval(rb, ax[i], ay[i], lob, hib);
            if (!(loa <= hib && lob <= hia))
                sep = 1'b1;
            ov = (hia < hib ? hia : hib) - (loa > lob ? loa : lob);
            if (i == 0 || ov < best)
            begin
                best = ov; nx = ax[i]; ny = ay[i];
            end
        end
        if (sep)
            return '0;
        dot = (rb.cx - ra.cx) * nx + (rb.cy - ra.cy) * ny;
        if (dot > 0)
        begin
            nx = -nx; ny = -ny;
        end
        dep = best >>> DSH;
        if (dep > (64'd1 << DW) - 1)
            dep = (64'd1 << DW) - 1;
        return {6'd0, dep[DW-1:0], ny[15:0], nx[15:0], 1'b1};
    endfunction

    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (!rst_n)
        begin
            fail_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                contact_q = {contact_q, sat_contact(s_tdata)};
            if (m_tvalid && m_tready)
            begin
                if (contact_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected item %h", m_tdata);
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (want[0] !== m_tdata[0] || want[16:1] !== m_tdata[16:1]
                        || want[32:17] !== m_tdata[32:17] || want[57:33] !== m_tdata[57:33])
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch hit %0d/%0d nx %0d/%0d ny %0d/%0d depth %0d/%0d",
                                want[0], m_tdata[0], $signed(want[16:1]),
                                $signed(m_tdata[16:1]), $signed(want[32:17]),
                                $signed(m_tdata[32:17]), want[57:33], m_tdata[57:33]);
                    end
                end
            end
        end
    end

endmodule

/* bench/oriented_rect_sat_collision_tb.sv */
// testbench top for the oriented rectangle collision block
// drives rectangle pairs and stalls; depends on orsat_pkg and the checker module
`timescale 1ns / 100ps
module oriented_rect_sat_collision_tb;
    import orsat_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    int               cycles;
    logic             drive_done;

    oriented_rect_sat_collision dut (.*);

    oriented_rect_sat_collision_checker chk (.*);

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [23:0] coord(int mode);
        if (mode == 0) return 24'($urandom);
        return 24'($signed($urandom_range(0, 8000)) - 4000);
    endfunction

    function automatic logic [22:0] half(int mode);
        if (mode == 0) return 23'($urandom);
        return 23'($urandom_range(0, 6000));
    endfunction

    function automatic logic [IN_W-1:0] pack_pair(
        logic [23:0] acx, logic [23:0] acy, logic [22:0] ahx, logic [22:0] ahy,
        logic [15:0] aang, logic [23:0] bcx, logic [23:0] bcy, logic [22:0] bhx,
        logic [22:0] bhy, logic [15:0] bang);
        return {4'd0, bang, bhy, bhx, bcy, bcx, aang, ahy, ahx, acy, acx};
    endfunction

    task automatic send(input logic [IN_W-1:0] d);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (!drive_done && cycles > 20000 && cycles < 25000)
            m_tready <= 1'b1;
        else if (r < 70)
            m_tready <= 1'b1;
        else if (r < 97)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int m;
        drive_done = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed pairs
        send(pack_pair(24'h800000, 24'h7fffff, 23'h7fffff, 23'h7fffff, 16'h0000,
                       24'h7fffff, 24'h800000, 23'h7fffff, 23'h7fffff, 16'hffff));
        send(pack_pair(0, 0, 256, 256, 0, 512, 0, 256, 256, 0));
        send(pack_pair(0, 0, 256, 256, 0, 513, 0, 256, 256, 0));
        send(pack_pair(0, 0, 256, 256, 0, 0, 0, 256, 256, 0));
        send(pack_pair(0, 0, 512, 256, 16'h2000, 100, 50, 300, 200, 16'h4000));
        send(pack_pair(0, 0, 512, 256, 16'h4000, -100, 0, 300, 200, 16'h8000));
        send(pack_pair(0, 0, 512, 256, 16'h8000, 0, 100, 300, 200, 16'hc000));
        send(pack_pair(0, 0, 512, 256, 16'hc000, 0, -100, 300, 200, 16'h3fff));
        send(pack_pair(0, 0, 0, 0, 16'h1234, 0, 0, 0, 0, 16'h5678));
        send(pack_pair(24'h7fffff, 24'h7fffff, 23'h7fffff, 0, 16'h7fff,
                       24'h800000, 24'h800000, 0, 23'h7fffff, 16'h8001));
        send(pack_pair(0, 0, 23'h7fffff, 23'h7fffff, 16'h2000,
                       0, 0, 23'h7fffff, 23'h7fffff, 16'h6000));
        send(pack_pair(24'hffffff, 24'hffffff, 23'h555555, 23'h2aaaaa, 16'haaaa,
                       24'h555555, 24'haaaaaa, 23'h2aaaaa, 23'h555555, 16'h5555));
        for (int i = 0; i < 1550; i++)
        begin
            m = ($urandom_range(0, 9) == 0) ? 0 : 1;
            send(pack_pair(coord(m), coord(m), half(m), half(m), 16'($urandom),
                           coord(m), coord(m), half(m), half(m), 16'($urandom)));
        end
        s_tvalid <= 1'b0;
        drive_done = 1'b1;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* oriented_rect_sat_collision.f */
+incdir+sv
sv/orsat_pkg.sv
sv/oriented_rect_sat_collision.sv
bench/oriented_rect_sat_collision_checker.sv
bench/oriented_rect_sat_collision_tb.sv
